>>> sv/lsts_pkg.sv
// Shared constants and action codes for the Latin-square table shuffler.
package lsts_pkg;

   localparam int BLOCK  = 4;
   localparam int SIZE   = BLOCK * BLOCK;
   localparam int IDX_W  = (SIZE > 1) ? $clog2(SIZE) : 1;
   localparam int BLK_W  = (BLOCK > 1) ? $clog2(BLOCK) : 1;
   localparam int ADDR_W = 2 * IDX_W;
   localparam int DEPTH  = 1 << ADDR_W;
   localparam int DATA_W = 8;
   localparam int T_W    = 9;

   localparam logic [T_W-1:0]   SIZE_T   = T_W'(SIZE);
   localparam logic [T_W-1:0]   BLOCK_T  = T_W'(BLOCK);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SIZE - 1);
   localparam logic [IDX_W-1:0] LAST_TR  = IDX_W'(SIZE - 2);
   localparam logic [IDX_W-1:0] LAST_BLK = IDX_W'(BLOCK - 1);
   localparam logic [IDX_W-1:0] BLOCK_I  = IDX_W'(BLOCK);

   localparam logic [2:0] ACT_READ      = 3'd0;
   localparam logic [2:0] ACT_FILL      = 3'd1;
   localparam logic [2:0] ACT_TRANSPOSE = 3'd2;
   localparam logic [2:0] ACT_SWAP_ROW  = 3'd3;
   localparam logic [2:0] ACT_SWAP_COL  = 3'd4;
   localparam logic [2:0] ACT_BAND_ROW  = 3'd5;
   localparam logic [2:0] ACT_BAND_COL  = 3'd6;

endpackage

>>> sv/lsts_ram.sv
// Generic simple dual-port RAM with registered read.
module lsts_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> sv/latin_square_table_shuffler.sv
// Top level of the Latin-square table shuffler: sequencer around one table memory.
//
// The block holds a SIZE x SIZE byte table (SIZE = BLOCK squared) in one RAM
// with one read and one write port, and handles one item at a time; req_stall
// is high from acceptance until the result has been placed in the output
// register. Every cell exchange runs through four steps (read, read, write,
// write), so the memory port sets the time per item; a rejected item goes
// straight to the result without touching the table. The result waits in its
// register until taken; the next item is accepted as soon as the sequencer is
// idle.
module latin_square_table_shuffler (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [2:0] req_action,
   input  logic [7:0] req_first,
   input  logic [7:0] req_second,
   input  logic [7:0] req_value,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_read_value,
   output logic       rsp_ignored
);

   import lsts_pkg::*;

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_FMOD  = 4'd1;
   localparam logic [3:0] S_FILL  = 4'd2;
   localparam logic [3:0] S_RDA   = 4'd3;
   localparam logic [3:0] S_RDB   = 4'd4;
   localparam logic [3:0] S_WRA   = 4'd5;
   localparam logic [3:0] S_WRB   = 4'd6;
   localparam logic [3:0] S_RWAIT = 4'd7;
   localparam logic [3:0] S_RESP  = 4'd8;

   logic [3:0]        state_ff, state_in;
   logic [2:0]        act_ff, act_in;
   logic [IDX_W-1:0]  ra_ff, ra_in;
   logic [IDX_W-1:0]  rb_ff, rb_in;
   logic [IDX_W-1:0]  n_ff, n_in;
   logic [IDX_W-1:0]  o_ff, o_in;
   logic [IDX_W-1:0]  olast_ff, olast_in;
   logic [T_W-1:0]    t_ff, t_in;
   logic [DATA_W-1:0] tmp_ff, tmp_in;
   logic [DATA_W-1:0] val_ff, val_in;
   logic [DATA_W-1:0] rd_ff, rd_in;
   logic              ign_ff, ign_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0] rsp_value_ff, rsp_value_in;
   logic              rsp_ign_ff, rsp_ign_in;

   logic              accept;
   logic              idx_bad, band_bad;
   logic [IDX_W-1:0]  band_base;
   logic [IDX_W-1:0]  line_a, line_b;
   logic [ADDR_W-1:0] addr_a, addr_b;
   logic [IDX_W-1:0]  fill_col;
   logic              fill_wrap;
   logic [T_W-1:0]    t_sum;
   logic [T_W-1:0]    t_next;
   logic              ram_we;
   logic [ADDR_W-1:0] ram_waddr, ram_raddr;
   logic [DATA_W-1:0] ram_wdata, ram_rdata;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != S_IDLE);

   assign idx_bad   = ({1'b0, req_first} >= SIZE_T) || ({1'b0, req_second} >= SIZE_T);
   assign band_bad  = ({1'b0, req_first} >= BLOCK_T) || ({1'b0, req_second} >= BLOCK_T);
   assign band_base = IDX_W'(req_first[BLK_W-1:0] * BLOCK_I);

   assign line_a = ra_ff + o_ff;
   assign line_b = rb_ff + o_ff;

   always_comb begin
      unique case (act_ff)
         ACT_READ: begin
            addr_a = {ra_ff, rb_ff};
            addr_b = {ra_ff, rb_ff};
         end
         ACT_TRANSPOSE: begin
            addr_a = {o_ff, n_ff};
            addr_b = {n_ff, o_ff};
         end
         ACT_SWAP_ROW, ACT_BAND_ROW: begin
            addr_a = {line_a, n_ff};
            addr_b = {line_b, n_ff};
         end
         ACT_SWAP_COL, ACT_BAND_COL: begin
            addr_a = {n_ff, line_a};
            addr_b = {n_ff, line_b};
         end
         default: begin
            addr_a = {n_ff, fill_col};
            addr_b = {n_ff, fill_col};
         end
      endcase
   end

   assign fill_col  = LAST_IDX - t_ff[IDX_W-1:0];
   assign fill_wrap = (o_ff == LAST_BLK);
   assign t_sum     = t_ff + BLOCK_T + {{(T_W-1){1'b0}}, fill_wrap};
   assign t_next    = (t_sum >= SIZE_T) ? (t_sum - SIZE_T) : t_sum;

   always_comb begin
      ram_we    = 1'b0;
      ram_waddr = addr_a;
      ram_wdata = ram_rdata;
      ram_raddr = (state_ff == S_RDB) ? addr_b : addr_a;
      unique case (state_ff)
         S_FILL: begin
            ram_we    = 1'b1;
            ram_wdata = val_ff;
         end
         S_WRA: begin
            ram_we = 1'b1;
         end
         S_WRB: begin
            ram_we    = 1'b1;
            ram_waddr = addr_b;
            ram_wdata = tmp_ff;
         end
         default: begin
            ram_we = 1'b0;
         end
      endcase
   end

   lsts_ram #(
      .WIDTH (DATA_W),
      .DEPTH (DEPTH)
   ) u_cells (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   always_comb begin
      state_in     = state_ff;
      act_in       = act_ff;
      ra_in        = ra_ff;
      rb_in        = rb_ff;
      n_in         = n_ff;
      o_in         = o_ff;
      olast_in     = olast_ff;
      t_in         = t_ff;
      tmp_in       = tmp_ff;
      val_in       = val_ff;
      rd_in        = rd_ff;
      ign_in       = ign_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_value_in = rsp_value_ff;
      rsp_ign_in   = rsp_ign_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               act_in   = req_action;
               ra_in    = IDX_W'(req_first);
               rb_in    = IDX_W'(req_second);
               n_in     = '0;
               o_in     = '0;
               olast_in = '0;
               t_in     = {1'b0, req_first};
               val_in   = req_value;
               rd_in    = '0;
               ign_in   = 1'b0;
               unique case (req_action)
                  ACT_READ: begin
                     ign_in   = idx_bad;
                     state_in = idx_bad ? S_RESP : S_RDA;
                  end
                  ACT_FILL: begin
                     state_in = S_FMOD;
                  end
                  ACT_TRANSPOSE: begin
                     n_in     = IDX_W'(1);
                     olast_in = LAST_TR;
                     state_in = S_RDA;
                  end
                  ACT_SWAP_ROW, ACT_SWAP_COL: begin
                     ign_in   = idx_bad;
                     state_in = idx_bad ? S_RESP : S_RDA;
                  end
                  ACT_BAND_ROW, ACT_BAND_COL: begin
                     ra_in    = band_base;
                     rb_in    = IDX_W'(req_second[BLK_W-1:0] * BLOCK_I);
                     olast_in = LAST_BLK;
                     ign_in   = band_bad;
                     state_in = band_bad ? S_RESP : S_RDA;
                  end
                  default: begin
                     ign_in   = 1'b1;
                     state_in = S_RESP;
                  end
               endcase
            end
         end
         S_FMOD: begin
            if (t_ff >= SIZE_T) begin
               t_in = t_ff - SIZE_T;
            end else begin
               state_in = S_FILL;
            end
         end
         S_FILL: begin
            t_in = t_next;
            o_in = fill_wrap ? '0 : o_ff + IDX_W'(1);
            n_in = n_ff + IDX_W'(1);
            if (n_ff == LAST_IDX) begin
               state_in = S_RESP;
            end
         end
         S_RDA: begin
            state_in = (act_ff == ACT_READ) ? S_RWAIT : S_RDB;
         end
         S_RDB: begin
            tmp_in   = ram_rdata;
            state_in = S_WRA;
         end
         S_WRA: begin
            state_in = S_WRB;
         end
         S_WRB: begin
            state_in = S_RDA;
            if (n_ff == LAST_IDX) begin
               if (o_ff == olast_ff) begin
                  state_in = S_RESP;
               end else begin
                  o_in = o_ff + IDX_W'(1);
                  n_in = (act_ff == ACT_TRANSPOSE) ? o_ff + IDX_W'(2) : '0;
               end
            end else begin
               n_in = n_ff + IDX_W'(1);
            end
         end
         S_RWAIT: begin
            rd_in    = ram_rdata;
            state_in = S_RESP;
         end
         S_RESP: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = rd_ff;
               rsp_ign_in   = ign_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      act_ff       <= act_in;
      ra_ff        <= ra_in;
      rb_ff        <= rb_in;
      n_ff         <= n_in;
      o_ff         <= o_in;
      olast_ff     <= olast_in;
      t_ff         <= t_in;
      tmp_ff       <= tmp_in;
      val_ff       <= val_in;
      rd_ff        <= rd_in;
      ign_ff       <= ign_in;
      rsp_value_ff <= rsp_value_in;
      rsp_ign_ff   <= rsp_ign_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_read_value = rsp_value_ff;
   assign rsp_ignored    = rsp_ign_ff;

   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff != S_IDLE)
      else $error("sequencer stayed idle after taking an item");

   a_resp_loads_output: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RESP && state_in == S_IDLE) |=> rsp_valid_ff)
      else $error("result dropped on return to idle");

   a_fill_offset_reduced: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_FILL |-> t_ff < SIZE_T)
      else $error("fill column offset not reduced");

   a_transpose_upper: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RDA && act_ff == ACT_TRANSPOSE) |-> n_ff > o_ff)
      else $error("transpose pair below diagonal");

   a_ignored_no_write: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RESP && ign_ff) |->
         ($past(state_ff) == S_IDLE || $past(state_ff) == S_RESP))
      else $error("rejected item touched the table");

endmodule
